### src/csgq_pkg.sv
// csgq_pkg: shared types and constants for the clip stack / glyph quad setup block
// no dependencies; imported by every module in src
`default_nettype none
package csgq_pkg;

	// default sizes, handed to the top level parameters
	localparam int STACK_DEPTH_DEF = 32;
	localparam int QUAD_SLOTS_DEF  = 4096;
	localparam int LAYERS_DEF      = 8;

	// atlas geometry: 16x16 cells, one cell is 2^12 in 0.16 uv
	localparam int CELL_SHIFT = 12;
	localparam int QUO_W      = CELL_SHIFT + 1;

	// command codes
	localparam logic [2:0] CMD_CLEAR  = 3'd0;
	localparam logic [2:0] CMD_PUSH   = 3'd1;
	localparam logic [2:0] CMD_REFINE = 3'd2;
	localparam logic [2:0] CMD_POP    = 3'd3;
	localparam logic [2:0] CMD_GLYPH  = 3'd4;

	// result status codes
	localparam logic [2:0] ST_VERTEX     = 3'd0;
	localparam logic [2:0] ST_REPORT     = 3'd1;
	localparam logic [2:0] ST_CULLED     = 3'd2;
	localparam logic [2:0] ST_STACK_FULL = 3'd3;
	localparam logic [2:0] ST_STORE_FULL = 3'd4;

	// configuration register indexes
	localparam logic CFG_FG = 1'b0;
	localparam logic CFG_BG = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POPRD,
		S_DIV,
		S_REPORT,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        w;
		logic [14:0]        h;
	} rect_t;

	// controller to datapath
	typedef struct packed {
		logic       latch_in;
		logic       op_clear;
		logic       op_push;
		logic       pop_rd;
		logic       pop_load;
		logic       div_start;
		logic       load_report;
		logic [2:0] report_code;
		logic       load_vertex;
		logic [1:0] vert_k;
		logic       bump_count;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] cmd;
		logic       stack_full;
		logic       stack_base;
		logic       visible;
		logic       store_full;
		logic       div_busy;
		logic       out_free;
	} sts_t;

endpackage
`default_nettype wire

### src/csgq_div.sv
// csgq_div: iterative divider giving floor(d * 2^12 / n) for d <= n, n > 0
// one quotient bit per cycle; uses csgq_pkg
`default_nettype none
module csgq_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [14:0]                   dividend,
	input  wire [14:0]                   divisor,
	output logic                         busy,
	output logic [csgq_pkg::QUO_W-1:0]   quo
);
	import csgq_pkg::*;

	logic [14:0]      rem_q;
	logic [14:0]      div_q;
	logic [QUO_W-1:0] quo_q;
	logic [3:0]       cnt_q;
	logic             busy_q;
	logic [15:0]      rem2;
	logic             bit_ge;

	assign rem2   = {rem_q, 1'b0};
	assign bit_ge = rem2 >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'(CELL_SHIFT);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 4'd1;
			if (cnt_q == 4'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			// whole part is one when the dividend is not below the divisor (that is, equal to it for d <= n)
			if (dividend >= divisor) begin
				rem_q <= dividend - divisor;
				quo_q <= QUO_W'(1);
			end else begin
				rem_q <= dividend;
				quo_q <= '0;
			end
		end else if (busy_q) begin
			rem_q <= bit_ge ? 15'(rem2 - {1'b0, div_q}) : rem2[14:0];
			quo_q <= {quo_q[QUO_W-2:0], bit_ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

### src/csgq_ctrl.sv
// csgq_ctrl: command sequencer for the clip stack / glyph quad setup block
// drives csgq_dp through ctl_t and reads sts_t; uses csgq_pkg
`default_nettype none
module csgq_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  csgq_pkg::sts_t     sts,
	output csgq_pkg::ctl_t     ctl
);
	import csgq_pkg::*;

	state_t     state_q, state_d;
	logic [2:0] rep_q, rep_d;
	logic [1:0] k_q, k_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rep_q   <= ST_REPORT;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			rep_q   <= rep_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		rep_d    = rep_q;
		k_d      = k_q;
		in_ready = 1'b0;
		ctl      = '0;
		ctl.report_code = rep_q;
		ctl.vert_k      = k_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.latch_in = 1'b1;
					state_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				rep_d   = ST_REPORT;
				state_d = S_REPORT;
				if (sts.cmd == CMD_CLEAR) begin
					ctl.op_clear = 1'b1;
				end else if (sts.cmd == CMD_PUSH || sts.cmd == CMD_REFINE) begin
					if (sts.stack_full) begin
						rep_d = ST_STACK_FULL;
					end else begin
						ctl.op_push = 1'b1;
					end
				end else if (sts.cmd == CMD_POP) begin
					if (!sts.stack_base) begin
						ctl.pop_rd = 1'b1;
						state_d    = S_POPRD;
					end
				end else if (sts.cmd == CMD_GLYPH) begin
					if (!sts.visible) begin
						rep_d = ST_CULLED;
					end else if (sts.store_full) begin
						rep_d = ST_STORE_FULL;
					end else begin
						ctl.div_start = 1'b1;
						state_d       = S_DIV;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
			S_POPRD: begin
				ctl.pop_load = 1'b1;
				state_d      = S_REPORT;
			end
			S_DIV: begin
				if (!sts.div_busy) begin
					k_d     = '0;
					state_d = S_EMIT;
				end
			end
			S_REPORT: begin
				if (sts.out_free) begin
					ctl.load_report = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					ctl.load_vertex = 1'b1;
					k_d             = k_q + 2'd1;
					if (k_q == 2'd3) begin
						ctl.bump_count = 1'b1;
						state_d        = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### src/csgq_dp.sv
// csgq_dp: datapath with clip stack memory, top registers, geometry, dividers and output beat
// instantiates csgq_div; uses csgq_pkg
`default_nettype none
module csgq_dp #(
	parameter int STACK_DEPTH = csgq_pkg::STACK_DEPTH_DEF,
	parameter int QUAD_SLOTS  = csgq_pkg::QUAD_SLOTS_DEF,
	parameter int LAYERS      = csgq_pkg::LAYERS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  csgq_pkg::ctl_t     ctl,
	output csgq_pkg::sts_t     sts,
	input  wire                cfg_valid,
	input  wire                cfg_index,
	input  wire [31:0]         cfg_data,
	input  wire [2:0]          cmd,
	input  wire signed [15:0]  rect_x,
	input  wire signed [15:0]  rect_y,
	input  wire [14:0]         rect_w,
	input  wire [14:0]         rect_h,
	input  wire [9:0]          glyph_code,
	input  wire [2:0]          layer,
	output logic               out_valid,
	input  wire                out_ready,
	output logic [2:0]         status,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic [14:0]        clip_w,
	output logic [14:0]        clip_h,
	output logic [13:0]        vertex_index,
	output logic [2:0]         layer_tag,
	output logic [31:0]        out_fg,
	output logic [31:0]        out_bg,
	output logic               last
);
	import csgq_pkg::*;

	localparam int SPW = $clog2(STACK_DEPTH);
	localparam int VCW = $clog2(4 * QUAD_SLOTS + 1);

	// latched command
	logic [2:0]         cmd_q;
	logic signed [15:0] rx_q, ry_q;
	logic [14:0]        rw_q, rh_q;
	logic [9:0]         code_q;
	logic [2:0]         layer_q;

	// stack
	rect_t              mem [STACK_DEPTH];
	rect_t              rd_q;
	rect_t              top_q, base_q;
	logic [SPW-1:0]     sp_q;
	logic [VCW-1:0]     count_q;
	logic [31:0]        fg_q, bg_q;

	// geometry
	logic signed [16:0] rx17, ry17, gx1, gy1, tx0, ty0, tx1, ty1;
	logic signed [16:0] x0, y0, x1, y1;
	logic signed [16:0] gx0_q, gy0_q, gx1_q, gy1_q;
	rect_t              new_rect;
	logic [14:0]        dd [4];
	logic [14:0]        dn [4];
	logic [QUO_W-1:0]   quo [4];
	logic [3:0]         busy;

	// output beat
	logic               ov_q;
	logic [2:0]         status_q;
	logic signed [16:0] px_q, py_q;
	logic [16:0]        u_q, v_q;
	logic [14:0]        cw_q, ch_q;
	logic [13:0]        vidx_q;
	logic [2:0]         lay_q;
	logic [31:0]        ofg_q, obg_q;
	logic               last_q;

	logic [16:0]        cu, cv, u0, u1, v0, v1;
	logic [31:0]        vidx_w;
	logic [2:0]         lay_sat;
	logic               out_free;

	assign rx17 = {rx_q[15], rx_q};
	assign ry17 = {ry_q[15], ry_q};
	assign gx1  = rx17 + $signed({2'b00, rw_q});
	assign gy1  = ry17 + $signed({2'b00, rh_q});
	assign tx0  = {top_q.x[15], top_q.x};
	assign ty0  = {top_q.y[15], top_q.y};
	assign tx1  = tx0 + $signed({2'b00, top_q.w});
	assign ty1  = ty0 + $signed({2'b00, top_q.h});
	assign x0   = (rx17 > tx0) ? rx17 : tx0;
	assign y0   = (ry17 > ty0) ? ry17 : ty0;
	assign x1   = (gx1 < tx1) ? gx1 : tx1;
	assign y1   = (gy1 < ty1) ? gy1 : ty1;

	always_comb begin
		if (cmd_q == CMD_REFINE) begin
			new_rect.x = x0[15:0];
			new_rect.y = y0[15:0];
			new_rect.w = (x1 > x0) ? 15'(x1 - x0) : '0;
			new_rect.h = (y1 > y0) ? 15'(y1 - y0) : '0;
		end else begin
			new_rect.x = rx_q;
			new_rect.y = ry_q;
			new_rect.w = rw_q;
			new_rect.h = rh_q;
		end
	end

	// dividends are offsets into the glyph box, never beyond its size
	// taken from the live clip corners, which the dividers load at start
	assign dd[0] = 15'(x0 - rx17);
	assign dd[1] = 15'(x1 - rx17);
	assign dd[2] = 15'(y0 - ry17);
	assign dd[3] = 15'(y1 - ry17);
	assign dn[0] = rw_q;
	assign dn[1] = rw_q;
	assign dn[2] = rh_q;
	assign dn[3] = rh_q;

	for (genvar i = 0; i < 4; i++) begin : g_div
		csgq_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (ctl.div_start),
			.dividend (dd[i]),
			.divisor  (dn[i]),
			.busy     (busy[i]),
			.quo      (quo[i])
		);
	end

	always_ff @(posedge clk) begin
		if (ctl.latch_in) begin
			cmd_q   <= cmd;
			rx_q    <= rect_x;
			ry_q    <= rect_y;
			rw_q    <= rect_w;
			rh_q    <= rect_h;
			code_q  <= glyph_code;
			layer_q <= layer;
		end
		if (ctl.div_start) begin
			gx0_q <= x0;
			gy0_q <= y0;
			gx1_q <= x1;
			gy1_q <= y1;
		end
		if (ctl.op_push) begin
			mem[SPW'(sp_q + 1'b1)] <= new_rect;
		end
		if (ctl.pop_rd) begin
			rd_q <= mem[SPW'(sp_q - 1'b1)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= '0;
			base_q  <= '0;
			sp_q    <= '0;
			count_q <= '0;
			fg_q    <= '0;
			bg_q    <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_FG) begin
					fg_q <= cfg_data;
				end else begin
					bg_q <= cfg_data;
				end
			end
			if (ctl.op_clear) begin
				top_q   <= '{x: '0, y: '0, w: rw_q, h: rh_q};
				base_q  <= '{x: '0, y: '0, w: rw_q, h: rh_q};
				sp_q    <= '0;
				count_q <= '0;
			end else if (ctl.op_push) begin
				top_q <= new_rect;
				sp_q  <= sp_q + 1'b1;
			end else if (ctl.pop_load) begin
				top_q <= (sp_q == SPW'(1)) ? base_q : rd_q;
				sp_q  <= sp_q - 1'b1;
			end else if (ctl.bump_count) begin
				count_q <= count_q + VCW'(4);
			end
		end
	end

	// uv: cell origin plus interpolated offset, zero for codes past the atlas
	assign cu = (code_q > 10'd255) ? '0 : 17'({code_q[3:0], {CELL_SHIFT{1'b0}}});
	assign cv = (code_q > 10'd255) ? '0 : 17'({code_q[7:4], {CELL_SHIFT{1'b0}}});
	assign u0 = (code_q > 10'd255) ? '0 : cu + 17'(quo[0]);
	assign u1 = (code_q > 10'd255) ? '0 : cu + 17'(quo[1]);
	assign v0 = (code_q > 10'd255) ? '0 : cv + 17'(quo[2]);
	assign v1 = (code_q > 10'd255) ? '0 : cv + 17'(quo[3]);

	assign vidx_w  = 32'(count_q) + 32'(ctl.vert_k);
	assign lay_sat = (32'(layer_q) >= LAYERS) ? 3'(LAYERS - 1) : layer_q;
	assign out_free = !ov_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ctl.load_report || ctl.load_vertex) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_report) begin
			status_q <= ctl.report_code;
			px_q     <= tx0;
			py_q     <= ty0;
			u_q      <= '0;
			v_q      <= '0;
			cw_q     <= top_q.w;
			ch_q     <= top_q.h;
			vidx_q   <= '0;
			lay_q    <= '0;
			ofg_q    <= '0;
			obg_q    <= '0;
			last_q   <= 1'b1;
		end else if (ctl.load_vertex) begin
			status_q <= ST_VERTEX;
			// corner order: x1y1, x1y0, x0y0, x0y1
			px_q     <= (ctl.vert_k[1]) ? gx0_q : gx1_q;
			py_q     <= (ctl.vert_k == 2'd1 || ctl.vert_k == 2'd2) ? gy0_q : gy1_q;
			u_q      <= (ctl.vert_k[1]) ? u0 : u1;
			v_q      <= (ctl.vert_k == 2'd1 || ctl.vert_k == 2'd2) ? v0 : v1;
			cw_q     <= top_q.w;
			ch_q     <= top_q.h;
			vidx_q   <= vidx_w[13:0];
			lay_q    <= lay_sat;
			ofg_q    <= fg_q;
			obg_q    <= bg_q;
			last_q   <= (ctl.vert_k == 2'd3);
		end
	end

	assign sts.cmd        = cmd_q;
	assign sts.stack_full = (sp_q == SPW'(STACK_DEPTH - 1));
	assign sts.stack_base = (sp_q == '0);
	assign sts.visible    = (x0 < x1) && (y0 < y1);
	assign sts.store_full = (32'(count_q) + 32'd4) > 32'(4 * QUAD_SLOTS);
	assign sts.div_busy   = |busy;
	assign sts.out_free   = out_free;

	assign out_valid    = ov_q;
	assign status       = status_q;
	assign pos_x        = px_q;
	assign pos_y        = py_q;
	assign tex_u        = u_q;
	assign tex_v        = v_q;
	assign clip_w       = cw_q;
	assign clip_h       = ch_q;
	assign vertex_index = vidx_q;
	assign layer_tag    = lay_q;
	assign out_fg       = ofg_q;
	assign out_bg       = obg_q;
	assign last         = last_q;
endmodule
`default_nettype wire

### src/clip_stack_glyph_quad_setup.sv
// clip_stack_glyph_quad_setup: top level, scissor stack plus clipped glyph quad generator
// clear/push/refine execute then report; pop reads the stack first; unused codes report nothing
// a visible glyph that fits runs 4 divider lanes (12 shift steps each), then emits four
// vertices, else reports; one command at a time; result back-pressure stalls the beats
// reset (arst_n, async low): stack to one empty base rect, vertex count and colours to zero
// depends on csgq_pkg, csgq_ctrl, csgq_dp
`default_nettype none
module clip_stack_glyph_quad_setup #(
	parameter int STACK_DEPTH = csgq_pkg::STACK_DEPTH_DEF,
	parameter int QUAD_SLOTS  = csgq_pkg::QUAD_SLOTS_DEF,
	parameter int LAYERS      = csgq_pkg::LAYERS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	// configuration writes, always taken
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire                cfg_index,
	input  wire [31:0]         cfg_data,
	// command beats
	input  wire                in_valid,
	output logic               in_ready,
	input  wire [2:0]          cmd,
	input  wire signed [15:0]  rect_x,
	input  wire signed [15:0]  rect_y,
	input  wire [14:0]         rect_w,
	input  wire [14:0]         rect_h,
	input  wire [9:0]          glyph_code,
	input  wire [2:0]          layer,
	// result beats
	output logic               out_valid,
	input  wire                out_ready,
	output logic [2:0]         status,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic [14:0]        clip_w,
	output logic [14:0]        clip_h,
	output logic [13:0]        vertex_index,
	output logic [2:0]         layer_tag,
	output logic [31:0]        out_fg,
	output logic [31:0]        out_bg,
	output logic               last
);
	import csgq_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// colour registers accept a write every cycle
	assign cfg_ready = 1'b1;

	// sequencer: idle, execute, optional pop read, divide, then report or four vertices
	csgq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// stack memory, top cache, clip geometry, uv dividers and the output beat register
	csgq_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.QUAD_SLOTS  (QUAD_SLOTS),
		.LAYERS      (LAYERS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.rect_x       (rect_x),
		.rect_y       (rect_y),
		.rect_w       (rect_w),
		.rect_h       (rect_h),
		.glyph_code   (glyph_code),
		.layer        (layer),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.clip_w       (clip_w),
		.clip_h       (clip_h),
		.vertex_index (vertex_index),
		.layer_tag    (layer_tag),
		.out_fg       (out_fg),
		.out_bg       (out_bg),
		.last         (last)
	);

	// one command in flight: no new beat taken right after one is accepted
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command accepted while another is in flight");

	// every non-vertex result closes its command
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_VERTEX |-> last)
		else $error("status result without last");

	// uv never exceeds one full texture
	a_uv_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_VERTEX |-> tex_u <= 17'd65536 && tex_v <= 17'd65536)
		else $error("uv out of range");

	// vertices of one quad carry consecutive indexes
	a_vidx_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && status == ST_VERTEX && !last
		|=> !out_valid || (status == ST_VERTEX && vertex_index == $past(vertex_index) + 14'd1))
		else $error("vertex index not consecutive within a quad");
endmodule
`default_nettype wire
